// File: rtl/hwin_pkg.sv
// Shared types and constants for the Hann window weight unit.
package hwin_pkg;

  localparam int LEN_W   = 13;  // window_length field
  localparam int IDX_W   = 12;  // sample_index field
  localparam int WGT_W   = 16;  // window_weight field
  localparam int DIVR_W  = 14;  // divisor 2*D
  localparam int QUO_W   = 32;  // quotient t
  localparam int Q30_W   = 31;  // Q30 values up to 1.0
  localparam int HORNER_STEPS = 6;

  // input reg, divider, fold, square, Horner, sine, sine square, round/output
  localparam int LATENCY = 1 + QUO_W + 1 + 1 + HORNER_STEPS + 1 + 1 + 1;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_PERIODIC_MODE = 1'b1;

  // Q30 Taylor coefficients of sin(pi*y/2): C1, C3, ... C13
  localparam logic [Q30_W-1:0] SINE_COEF [7] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  typedef struct packed {
    logic valid;
    logic oor;        // index not below length
    logic force_one;  // symmetric window of length one
  } tag_t;

endpackage

// File: rtl/hwin_div.sv
// Pipelined restoring divider: t = floor((j*2^32 + D) / (2*D)), one quotient bit per stage.
module hwin_div (
  input  logic                        clk,
  input  logic                        rst,
  input  hwin_pkg::tag_t              in_tag,
  input  logic [hwin_pkg::IDX_W-1:0]  in_j,
  input  logic [hwin_pkg::DIVR_W-1:0] in_div,
  output hwin_pkg::tag_t              out_tag,
  output logic [hwin_pkg::QUO_W-1:0]  out_q
);

  localparam int NS = hwin_pkg::QUO_W;
  localparam int DW = hwin_pkg::DIVR_W;

  hwin_pkg::tag_t          tag [NS+1];
  logic [DW-1:0]           rem [NS+1];
  logic [DW-1:0]           dv  [NS+1];
  logic [NS-1:0]           q   [NS+1];

  assign tag[0] = in_tag;
  assign rem[0] = DW'(in_j);
  assign dv[0]  = in_div;
  assign q[0]   = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NS-1:0] dlo;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    // low word of the numerator is D itself
    assign dlo  = NS'(dv[k][DW-1:1]);
    assign sh   = {rem[k], dlo[NS-1-k]};
    assign ge   = sh >= {1'b0, dv[k]};
    assign diff = sh - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k+1] <= '0;
      end else begin
        tag[k+1] <= tag[k];
      end
      rem[k+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
      dv[k+1]  <= dv[k];
      q[k+1]   <= {q[k][NS-2:0], ge};
    end
  end

  assign out_tag = tag[NS];
  assign out_q   = q[NS];

endmodule

// File: rtl/hann_window_weight_unit.sv
// Hann window weight unit: Q1.F weight sin(pi*j/D)^2 for a sample index.
// Throughput: one word per clock; busy is never raised and done cannot be held off.
// The latency is set by the 32-stage quotient pipeline plus the polynomial stages.
// Synchronous reset clears all valid bits and loads length 1024, symmetric mode.
module hann_window_weight_unit #(
  parameter int MAX_LENGTH       = 4096,
  parameter int WEIGHT_FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [hwin_pkg::LEN_W-1:0]   cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic [hwin_pkg::IDX_W-1:0]   sample_index,
  output logic                         done,
  output logic [hwin_pkg::WGT_W-1:0]   window_weight,
  output logic                         index_out_of_range
);

  localparam int LW  = hwin_pkg::LEN_W;
  localparam int QW  = hwin_pkg::Q30_W;
  localparam int HS  = hwin_pkg::HORNER_STEPS;
  localparam int LEN_CAP = (MAX_LENGTH > 8191) ? 8191 : MAX_LENGTH;
  localparam logic [LW-1:0] LEN_MAX = LW'(LEN_CAP);
  localparam int SH  = 60 - WEIGHT_FRAC_BITS;
  localparam logic [61:0] RND = 62'(1) << (59 - WEIGHT_FRAC_BITS);
  localparam int WW  = WEIGHT_FRAC_BITS + 1;
  localparam logic [WW-1:0] W_ONE = WW'(1) << WEIGHT_FRAC_BITS;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << 30;

  logic [LW-1:0] window_length;
  logic          periodic_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LW'(1024);
      periodic_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        hwin_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
        hwin_pkg::REG_PERIODIC_MODE: periodic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage
  logic [LW-1:0]  len_sat;
  logic [LW-1:0]  d_val;
  hwin_pkg::tag_t in_tag_next;
  hwin_pkg::tag_t in_tag;
  logic [hwin_pkg::IDX_W-1:0]  in_j;
  logic [hwin_pkg::DIVR_W-1:0] in_div;

  always_comb begin
    len_sat = (window_length > LEN_MAX) ? LEN_MAX : window_length;
    d_val   = periodic_mode ? len_sat : len_sat - LW'(1);
    in_tag_next.valid     = start && !busy;
    in_tag_next.oor       = LW'(sample_index) >= len_sat;
    in_tag_next.force_one = !periodic_mode && (len_sat == LW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag <= '0;
    end else begin
      in_tag <= in_tag_next;
    end
    in_j   <= sample_index;
    in_div <= {d_val, 1'b0};
  end

  hwin_pkg::tag_t             div_tag;
  logic [hwin_pkg::QUO_W-1:0] div_q;

  hwin_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (in_tag),
    .in_j    (in_j),
    .in_div  (in_div),
    .out_tag (div_tag),
    .out_q   (div_q)
  );

  // fold onto the quarter wave: sin(pi*x) = sin(pi*(1-x))
  hwin_pkg::tag_t fold_tag;
  logic [QW-1:0]  fold_t;
  logic [QW-1:0]  fold_t_next;

  always_comb begin
    if (div_q > 32'h4000_0000) begin
      fold_t_next = (div_q >= 32'h8000_0000) ? '0 : QW'(32'h8000_0000 - div_q);
    end else begin
      fold_t_next = div_q[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_tag <= '0;
    end else begin
      fold_tag <= div_tag;
    end
    fold_t <= fold_t_next;
  end

  // y^2
  hwin_pkg::tag_t sq_tag;
  logic [QW-1:0]  sq_t;
  logic [QW-1:0]  sq_y2;
  logic [61:0]    tt_prod;

  assign tt_prod = fold_t * fold_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tag <= '0;
    end else begin
      sq_tag <= fold_tag;
    end
    sq_t  <= fold_t;
    sq_y2 <= tt_prod[60:30];
  end

  // Horner chain, one coefficient per stage
  hwin_pkg::tag_t h_tag [HS+1];
  logic [QW-1:0]  h_t   [HS+1];
  logic [QW-1:0]  h_y2  [HS+1];
  logic [QW-1:0]  h_p   [HS+1];

  assign h_tag[0] = sq_tag;
  assign h_t[0]   = sq_t;
  assign h_y2[0]  = sq_y2;
  assign h_p[0]   = hwin_pkg::SINE_COEF[HS];

  for (genvar h = 0; h < HS; h++) begin : g_horner
    logic [61:0] prod;
    assign prod = h_y2[h] * h_p[h];

    always_ff @(posedge clk) begin
      if (rst) begin
        h_tag[h+1] <= '0;
      end else begin
        h_tag[h+1] <= h_tag[h];
      end
      h_t[h+1]  <= h_t[h];
      h_y2[h+1] <= h_y2[h];
      h_p[h+1]  <= hwin_pkg::SINE_COEF[HS-1-h] - prod[60:30];
    end
  end

  // sine
  hwin_pkg::tag_t s_tag;
  logic [QW-1:0]  s_val;
  logic [61:0]    tp_prod;

  assign tp_prod = h_t[HS] * h_p[HS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tag <= '0;
    end else begin
      s_tag <= h_tag[HS];
    end
    s_val <= (tp_prod[61:30] > 32'(Q_ONE)) ? Q_ONE : tp_prod[60:30];
  end

  // sine squared
  hwin_pkg::tag_t ss_tag;
  logic [61:0]    ss_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      ss_tag <= '0;
    end else begin
      ss_tag <= s_tag;
    end
    ss_val <= s_val * s_val;
  end

  // round, clamp, select
  logic [61:0]   rnd_sum;
  logic [61:0]   w_full;
  logic [WW-1:0] w_val;
  logic [63:0]   w_ext;
  logic [hwin_pkg::WGT_W-1:0] weight_next;

  always_comb begin
    rnd_sum = ss_val + RND;
    w_full  = rnd_sum >> SH;
    w_val   = (w_full > 62'(W_ONE)) ? W_ONE : w_full[WW-1:0];
    if (ss_tag.oor) begin
      w_ext = '0;
    end else if (ss_tag.force_one) begin
      w_ext = 64'(W_ONE);
    end else begin
      w_ext = 64'(w_val);
    end
    weight_next = w_ext[hwin_pkg::WGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ss_tag.valid;
    end
    window_weight      <= weight_next;
    index_out_of_range <= ss_tag.oor;
  end

endmodule

// File: rtl/hwin_check.sv
// Port-level checks for the Hann window weight unit, bound to the top level.
module hwin_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] window_weight,
  input logic        index_out_of_range
);

  // every result word comes from an accepted word a fixed latency earlier
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hwin_pkg::LATENCY))
    else $error("result word without matching accepted word");

  // every accepted word yields a result word a fixed latency later
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hwin_pkg::LATENCY) (done || $past(rst, hwin_pkg::LATENCY - 1)))
    else $error("accepted word lost");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_out_of_range) |-> (window_weight == 16'd0))
    else $error("out-of-range index with nonzero weight");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");

endmodule

bind hann_window_weight_unit hwin_check u_hwin_check (.*);
